@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/ppfc_pkg.sv @@
// ----------------------------------------------------------------------------
// Packed pixel format converter package
// Format codes, format descriptor table and per-channel rescale helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package ppfc_pkg;

	localparam int PIX_W  = 32;
	localparam int FMT_W  = 4;
	localparam int CHAN_N = 4;
	localparam int CH_A   = 3;	// alpha channel slot

	// Format codes
	localparam logic [FMT_W-1:0] FMT_RGBA8888 = 4'd0;
	localparam logic [FMT_W-1:0] FMT_BGRX8888 = 4'd1;
	localparam logic [FMT_W-1:0] FMT_A8       = 4'd2;
	localparam logic [FMT_W-1:0] FMT_R8       = 4'd3;
	localparam logic [FMT_W-1:0] FMT_BGR565   = 4'd4;
	localparam logic [FMT_W-1:0] FMT_BGRA5551 = 4'd5;
	localparam logic [FMT_W-1:0] FMT_BGRA4444 = 4'd6;
	localparam logic [FMT_W-1:0] FMT_BGRA8888 = 4'd7;
	localparam logic [FMT_W-1:0] FMT_ARGB4444 = 4'd8;

	// Configuration register indexes
	localparam logic REG_SOURCE_FORMAT = 1'b0;
	localparam logic REG_TARGET_FORMAT = 1'b1;

	// Container sizes
	localparam logic [5:0] SIZE_8  = 6'd8;
	localparam logic [5:0] SIZE_16 = 6'd16;
	localparam logic [5:0] SIZE_32 = 6'd32;

	typedef struct packed {
		logic                   known;
		logic [5:0]             size;
		logic [CHAN_N-1:0][3:0] bits;	// r, g, b, a at index 0..3
		logic [CHAN_N-1:0][4:0] pos;
	} fmt_desc_t;

	function automatic fmt_desc_t mk_desc(
		input logic [5:0] size,
		input logic [3:0] br, input logic [3:0] bg,
		input logic [3:0] bb, input logic [3:0] ba,
		input logic [4:0] pr, input logic [4:0] pg,
		input logic [4:0] pb, input logic [4:0] pa
	);
		fmt_desc_t d;
		d.known   = 1'b1;
		d.size    = size;
		d.bits[0] = br;
		d.bits[1] = bg;
		d.bits[2] = bb;
		d.bits[3] = ba;
		d.pos[0]  = pr;
		d.pos[1]  = pg;
		d.pos[2]  = pb;
		d.pos[3]  = pa;
		return d;
	endfunction

	// Format code to descriptor; codes above the table give an unknown format
	function automatic fmt_desc_t fmt_desc(input logic [FMT_W-1:0] code);
		fmt_desc_t d;
		d = '0;
		unique case (code)
			FMT_RGBA8888: d = mk_desc(SIZE_32, 4'd8, 4'd8, 4'd8, 4'd8,
				5'd0, 5'd8, 5'd16, 5'd24);
			FMT_BGRX8888: d = mk_desc(SIZE_32, 4'd8, 4'd8, 4'd8, 4'd0,
				5'd16, 5'd8, 5'd0, 5'd0);
			FMT_A8:       d = mk_desc(SIZE_8, 4'd0, 4'd0, 4'd0, 4'd8,
				5'd0, 5'd0, 5'd0, 5'd0);
			FMT_R8:       d = mk_desc(SIZE_8, 4'd8, 4'd0, 4'd0, 4'd0,
				5'd0, 5'd0, 5'd0, 5'd0);
			FMT_BGR565:   d = mk_desc(SIZE_16, 4'd5, 4'd6, 4'd5, 4'd0,
				5'd11, 5'd5, 5'd0, 5'd0);
			// alpha sits in the top bit of the word
			FMT_BGRA5551: d = mk_desc(SIZE_16, 4'd5, 4'd5, 4'd5, 4'd1,
				5'd10, 5'd5, 5'd0, 5'd15);
			FMT_BGRA4444: d = mk_desc(SIZE_16, 4'd4, 4'd4, 4'd4, 4'd4,
				5'd8, 5'd4, 5'd0, 5'd12);
			FMT_BGRA8888: d = mk_desc(SIZE_32, 4'd8, 4'd8, 4'd8, 4'd8,
				5'd16, 5'd8, 5'd0, 5'd24);
			FMT_ARGB4444: d = mk_desc(SIZE_16, 4'd4, 4'd4, 4'd4, 4'd4,
				5'd4, 5'd8, 5'd12, 5'd0);
			default:      d = '0;
		endcase
		return d;
	endfunction

	// Low n bits set, n up to 8
	function automatic logic [7:0] chan_mask(input logic [3:0] n);
		logic [8:0] m;
		m = (9'd1 << n) - 9'd1;
		return m[7:0];
	endfunction

	// Mask of a whole container
	function automatic logic [PIX_W-1:0] cont_mask(input logic [5:0] size);
		logic [PIX_W-1:0] m;
		case (size)
			SIZE_8:  m = 32'h0000_00FF;
			SIZE_16: m = 32'h0000_FFFF;
			SIZE_32: m = 32'hFFFF_FFFF;
			default: m = '0;
		endcase
		return m;
	endfunction

	// Widen by shift-left with the top bits replicated below, narrow by shift-right
	function automatic logic [7:0] rescale(
		input logic [7:0] v,
		input logic [3:0] s,
		input logic [3:0] d
	);
		logic [3:0] up;
		logic [4:0] twice;
		logic [4:0] back;
		logic [7:0] r;
		up    = d - s;
		twice = {s, 1'b0};
		back  = (twice > {1'b0, d}) ? (twice - {1'b0, d}) : 5'd0;
		if (s < d) begin
			r = (v << up) | (v >> back);
		end else begin
			r = v >> (s - d);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ hdl/ppfc_src_if.sv @@
// ----------------------------------------------------------------------------
// Source pixel channel
// Valid/ready channel carrying one packed source pixel per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface ppfc_src_if import ppfc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] source_pixel;

	modport source (output valid, output source_pixel, input ready);
	modport sink   (input valid, input source_pixel, output ready);
endinterface

`default_nettype wire

@@ hdl/ppfc_dst_if.sv @@
// ----------------------------------------------------------------------------
// Target pixel channel
// Valid/ready channel carrying one packed converted pixel per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface ppfc_dst_if import ppfc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] target_pixel;

	modport source (output valid, output target_pixel, input ready);
	modport sink   (input valid, input target_pixel, output ready);
endinterface

`default_nettype wire

@@ hdl/ppfc_convert.sv @@
// ----------------------------------------------------------------------------
// Pixel conversion datapath
// Raw pass-through test, per-channel extract, rescale and repack.
// ----------------------------------------------------------------------------
`default_nettype none

module ppfc_convert import ppfc_pkg::*; (
	input  wire logic [FMT_W-1:0] source_format,
	input  wire logic [FMT_W-1:0] target_format,
	input  wire logic [PIX_W-1:0] source_pixel,
	output logic      [PIX_W-1:0] target_pixel
);

	fmt_desc_t        sd;
	fmt_desc_t        td;
	logic             raw;
	logic [PIX_W-1:0] packed_px;
	logic [PIX_W-1:0] shifted;
	logic [7:0]       field;
	logic [7:0]       v;

	always_comb begin
		sd = fmt_desc(source_format);
		td = fmt_desc(target_format);

		// Raw copy when containers match and no present target channel moves
		raw = (sd.size == td.size);
		for (int c = 0; c < CHAN_N; c++) begin
			if (td.bits[c] != 4'd0 &&
			    (sd.bits[c] != td.bits[c] || sd.pos[c] != td.pos[c])) begin
				raw = 1'b0;
			end
		end

		// Per-channel repack; channels are independent
		packed_px = '0;
		shifted   = '0;
		field     = '0;
		v         = '0;
		for (int c = 0; c < CHAN_N; c++) begin
			shifted = source_pixel >> sd.pos[c];
			field   = shifted[7:0] & chan_mask(sd.bits[c]);
			if (sd.bits[c] != 4'd0) begin
				v = rescale(field, sd.bits[c], td.bits[c]);
			end else if (c == CH_A) begin
				v = chan_mask(td.bits[c]);	// absent alpha is opaque
			end else begin
				v = 8'd0;
			end
			packed_px = packed_px | ({{(PIX_W-8){1'b0}}, v} << td.pos[c]);
		end

		if (!sd.known || !td.known) begin
			target_pixel = '0;
		end else if (raw) begin
			target_pixel = source_pixel & cont_mask(sd.size);
		end else begin
			target_pixel = packed_px & cont_mask(td.size);
		end
	end

endmodule

`default_nettype wire

@@ hdl/packed_pixel_format_converter_unit.sv @@
// ----------------------------------------------------------------------------
// Packed pixel format converter
// Converts a stream of packed pixels between nine RGBA-style formats.
//
//   channel | direction | protocol        | payload
//   --------+-----------+-----------------+------------------------
//   src     | in        | valid/ready     | source_pixel  [31:0]
//   dst     | out       | valid/ready     | target_pixel  [31:0]
//   cfg     | in        | write enable    | cfg_index [0], cfg_data [3:0]
//
// One pixel per clock sustained while dst.ready is high; a pixel passes the input
// register, then the conversion logic into the result register.
// Throughput is set by the two-stage register pipeline; dst.ready low holds a
// full stage 2, and src.ready drops only once both stages hold a pixel.
// arst_n clears the stage valid flags and both format registers (code 0).
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module packed_pixel_format_converter_unit import ppfc_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic             cfg_index,
	input  wire logic [FMT_W-1:0] cfg_data,
	ppfc_src_if.sink              src,
	ppfc_dst_if.source            dst
);

	logic [FMT_W-1:0] src_fmt_q;
	logic [FMT_W-1:0] dst_fmt_q;
	logic             valid_s1;
	logic [PIX_W-1:0] pixel_s1;
	logic             valid_s2;
	logic [PIX_W-1:0] pixel_s2;
	logic [PIX_W-1:0] converted;
	logic             adv_s2;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_fmt_q <= FMT_RGBA8888;
			dst_fmt_q <= FMT_RGBA8888;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_SOURCE_FORMAT: src_fmt_q <= cfg_data;
				REG_TARGET_FORMAT: dst_fmt_q <= cfg_data;
				default:           ;
			endcase
		end
	end

	// Stage handshake
	assign adv_s2    = !valid_s2 || dst.ready;
	assign src.ready = !valid_s1 || adv_s2;

	// Stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (src.ready) begin
				valid_s1 <= src.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Stage payloads
	always_ff @(posedge clk) begin
		if (src.ready) begin
			pixel_s1 <= src.source_pixel;
		end
		if (adv_s2) begin
			pixel_s2 <= converted;
		end
	end

	ppfc_convert u_convert (
		.source_format (src_fmt_q),
		.target_format (dst_fmt_q),
		.source_pixel  (pixel_s1),
		.target_pixel  (converted)
	);

	assign dst.valid        = valid_s2;
	assign dst.target_pixel = pixel_s2;

	// Checks
	`ASSERT_NEXT(a_s1_moves, valid_s1 && adv_s2, valid_s2, "stage 1 pixel not passed on")
	`ASSERT_NEXT(a_s1_holds, valid_s1 && !adv_s2, valid_s1 && $stable(pixel_s1),
		"stalled stage 1 pixel lost")
	`ASSERT_IMPL(a_s2_source, $rose(valid_s2), $past(valid_s1), "result without a pixel")

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// Packed pixel format converter testbench
// Streams packed pixels through the converter under a range of source and
// target formats, with random gaps on the source channel and random stalls on
// the target channel. Each accepted pixel is converted by a local bit-level
// model and the expected words are checked in order against the results.
// ----------------------------------------------------------------------------
module tb_top;
	import ppfc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned FMT_COUNT  = 9;	// codes 9 and up name no format
	localparam int unsigned RAND_ITEMS = 1850;
	localparam int unsigned STALL_MAX  = 9;
	localparam int unsigned IDLE_LIMIT = 1000;
	localparam int unsigned PIPE_TAIL  = 8;	// two-stage pipeline, with margin

	localparam logic [FMT_W-1:0] FMT_UNUSED_LOW = FMT_ARGB4444 + 1'b1;
	localparam logic [FMT_W-1:0] FMT_UNUSED_TOP = '1;

	// Container width and, alpha first, per-channel widths and bit positions
	typedef struct packed {
		logic [5:0]             width;
		logic [CHAN_N-1:0][3:0] nbits;
		logic [CHAN_N-1:0][4:0] at;
	} pix_layout_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cfg_wr_en = 1'b0;
	logic                cfg_index = REG_SOURCE_FORMAT;
	logic [FMT_W-1:0]    cfg_data  = FMT_RGBA8888;
	logic                in_valid  = 1'b0;
	logic [PIX_W-1:0]    in_pixel  = '0;
	logic                out_ready = 1'b0;

	ppfc_src_if src_ch ();
	ppfc_dst_if dst_ch ();

	assign src_ch.valid        = in_valid;
	assign src_ch.source_pixel = in_pixel;
	assign dst_ch.ready        = out_ready;

	packed_pixel_format_converter_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.src       (src_ch),
		.dst       (dst_ch)
	);

	// Model copy of the format registers
	logic [FMT_W-1:0] model_src_fmt = FMT_RGBA8888;
	logic [FMT_W-1:0] model_dst_fmt = FMT_RGBA8888;

	logic [PIX_W-1:0] pending_pixels[$];
	logic [PIX_W-1:0] expected_pixels[$];
	int unsigned      mismatches = 0;
	int unsigned      pixels_sent = 0;
	bit               idle_on = 1'b1;
	int unsigned      feed_gap;
	int unsigned      sink_hold;
	int unsigned      quiet_cycles;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic longint unsigned low_ones(input int unsigned n);
		return (64'd1 << n) - 64'd1;
	endfunction

	function automatic pix_layout_t pixel_layout(input logic [FMT_W-1:0] code);
		pix_layout_t l;
		l = '0;
		case (code)
			FMT_RGBA8888: begin
				l.width = 6'd32;
				l.nbits = {4'd8, 4'd8, 4'd8, 4'd8};
				l.at    = {5'd24, 5'd16, 5'd8, 5'd0};
			end
			FMT_BGRX8888: begin
				l.width = 6'd32;
				l.nbits = {4'd0, 4'd8, 4'd8, 4'd8};
				l.at    = {5'd0, 5'd0, 5'd8, 5'd16};
			end
			FMT_A8: begin
				l.width = 6'd8;
				l.nbits = {4'd8, 4'd0, 4'd0, 4'd0};
			end
			FMT_R8: begin
				l.width = 6'd8;
				l.nbits = {4'd0, 4'd0, 4'd0, 4'd8};
			end
			FMT_BGR565: begin
				l.width = 6'd16;
				l.nbits = {4'd0, 4'd5, 4'd6, 4'd5};
				l.at    = {5'd0, 5'd0, 5'd5, 5'd11};
			end
			FMT_BGRA5551: begin
				l.width = 6'd16;
				l.nbits = {4'd1, 4'd5, 4'd5, 4'd5};
				l.at    = {5'd15, 5'd0, 5'd5, 5'd10};
			end
			FMT_BGRA4444: begin
				l.width = 6'd16;
				l.nbits = {4'd4, 4'd4, 4'd4, 4'd4};
				l.at    = {5'd12, 5'd0, 5'd4, 5'd8};
			end
			FMT_BGRA8888: begin
				l.width = 6'd32;
				l.nbits = {4'd8, 4'd8, 4'd8, 4'd8};
				l.at    = {5'd24, 5'd0, 5'd8, 5'd16};
			end
			FMT_ARGB4444: begin
				l.width = 6'd16;
				l.nbits = {4'd4, 4'd4, 4'd4, 4'd4};
				l.at    = {5'd0, 5'd12, 5'd8, 5'd4};
			end
			default: l = '0;
		endcase
		return l;
	endfunction

	// Expected target word for one source pixel
	function automatic logic [PIX_W-1:0] convert_pixel(
		input logic [FMT_W-1:0] from_fmt,
		input logic [FMT_W-1:0] to_fmt,
		input logic [PIX_W-1:0] px
	);
		pix_layout_t       sl;
		pix_layout_t       tl;
		bit                passthru;
		longint unsigned   v;
		longint unsigned   res;
		int unsigned       s;
		int unsigned       d;
		int unsigned       back;
		if (from_fmt >= FMT_COUNT || to_fmt >= FMT_COUNT)
			return '0;
		sl = pixel_layout(from_fmt);
		tl = pixel_layout(to_fmt);

		// raw copy when the containers agree and no present target channel moves
		passthru = (sl.width == tl.width);
		for (int c = 0; c < CHAN_N; c++) begin
			if (tl.nbits[c] != 0 &&
				(sl.nbits[c] != tl.nbits[c] || sl.at[c] != tl.at[c]))
				passthru = 1'b0;
		end
		if (passthru)
			return px & PIX_W'(low_ones(sl.width));

		res = 0;
		for (int c = 0; c < CHAN_N; c++) begin
			s = sl.nbits[c];
			d = tl.nbits[c];
			if (s != 0) begin
				v = (px >> sl.at[c]) & low_ones(s);
				if (s < d) begin
					back = (2 * s > d) ? (2 * s - d) : 0;
					v = (v << (d - s)) | (v >> back);
				end else begin
					v = v >> (s - d);
				end
			end else if (c == CH_A) begin
				v = low_ones(d);	// missing alpha reads as opaque
			end else begin
				v = 0;
			end
			res |= v << tl.at[c];
		end
		return res[PIX_W-1:0] & PIX_W'(low_ones(tl.width));
	endfunction

	function automatic int unsigned draw_wait();
		return idle_on ? $urandom_range(0, STALL_MAX) : 0;
	endfunction

	function automatic logic [PIX_W-1:0] random_pixel();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2:       return 32'd1 << $urandom_range(0, PIX_W - 1);
			3:       return ~(32'd1 << $urandom_range(0, PIX_W - 1));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [FMT_W-1:0] random_format();
		if ($urandom_range(0, 19) < 17)
			return FMT_W'($urandom_range(0, FMT_COUNT - 1));
		return FMT_W'($urandom_range(FMT_UNUSED_LOW, FMT_UNUSED_TOP));
	endfunction

	// Source side: present pending pixels, predict on each transfer
	always @(posedge clk or negedge arst_n) begin : feed_side
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_pixel <= '0;
			feed_gap <= 0;
		end else begin
			if (in_valid && src_ch.ready)
				expected_pixels.push_back(convert_pixel(model_src_fmt, model_dst_fmt,
					in_pixel));
			if (!in_valid || src_ch.ready) begin
				if (feed_gap != 0) begin
					in_valid <= 1'b0;
					feed_gap <= feed_gap - 1;
				end else if (pending_pixels.size() != 0) begin
					in_valid <= 1'b1;
					in_pixel <= pending_pixels.pop_front();
					feed_gap <= draw_wait();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Target side: random back-pressure, in-order compare on each transfer
	always @(posedge clk or negedge arst_n) begin : sink_side
		int unsigned      hold_n;
		logic [PIX_W-1:0] want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			sink_hold <= 0;
		end else begin
			hold_n = sink_hold;
			if (dst_ch.valid && out_ready) begin
				if (expected_pixels.size() == 0) begin
					$display("%0t: unexpected target pixel %h", $time, dst_ch.target_pixel);
					mismatches++;
				end else begin
					want = expected_pixels.pop_front();
					if (dst_ch.target_pixel !== want) begin
						$display("%0t: target_pixel expected %h actual %h",
							$time, want, dst_ch.target_pixel);
						mismatches++;
					end
				end
				hold_n = draw_wait();
			end
			if (hold_n != 0) begin
				out_ready <= 1'b0;
				sink_hold <= hold_n - 1;
			end else begin
				out_ready <= 1'b1;
				sink_hold <= 0;
			end
		end
	end

	// Watchdog on cycles with no transfer on either channel
	always @(posedge clk or negedge arst_n) begin : watchdog
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((in_valid && src_ch.ready) || (dst_ch.valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("packed_pixel_format_converter_unit test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Wait until every pixel has gone through, then let the pipeline settle;
	// sampled mid-cycle so the driver's updates at the edge are settled
	task automatic drain_pipe();
		do
			@(negedge clk);
		while (pending_pixels.size() != 0 || in_valid || expected_pixels.size() != 0);
		repeat (PIPE_TAIL) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [FMT_W-1:0] code);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= code;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == REG_SOURCE_FORMAT)
			model_src_fmt = code;
		else
			model_dst_fmt = code;
	endtask

	task automatic set_formats(input logic [FMT_W-1:0] from_fmt,
		input logic [FMT_W-1:0] to_fmt);
		write_reg(REG_SOURCE_FORMAT, from_fmt);
		write_reg(REG_TARGET_FORMAT, to_fmt);
	endtask

	task automatic random_phase(input logic [FMT_W-1:0] from_fmt,
		input logic [FMT_W-1:0] to_fmt, input int unsigned count, input bit mid_pause);
		set_formats(from_fmt, to_fmt);
		for (int unsigned i = 0; i < count; i++) begin
			pending_pixels.push_back(random_pixel());
			// hold the source back until the target side has caught up
			if (mid_pause && i == count / 2)
				drain_pipe();
		end
		pixels_sent += count;
		drain_pipe();
	endtask

	initial begin : stimulus
		int unsigned phase_no;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Single-bit alpha widening, colour widening from five bits
		set_formats(FMT_BGRA5551, FMT_RGBA8888);
		pending_pixels.push_back(32'h0000_0000);
		pending_pixels.push_back(32'h0000_FFFF);
		pending_pixels.push_back(32'h0000_8000);
		pending_pixels.push_back(32'h0000_7FFF);
		pending_pixels.push_back(32'hFFFF_0421);
		drain_pipe();

		// Raw copy keeps the bits under the absent target alpha
		set_formats(FMT_BGRA8888, FMT_BGRX8888);
		pending_pixels.push_back(32'hFFFF_FFFF);
		pending_pixels.push_back(32'hA500_0000);
		pending_pixels.push_back(32'h0000_0000);
		drain_pipe();

		// Missing colour reads as zero
		set_formats(FMT_A8, FMT_BGRA4444);
		pending_pixels.push_back(32'h0000_00FF);
		pending_pixels.push_back(32'h0000_0000);
		pending_pixels.push_back(32'hFFFF_FF80);
		drain_pipe();

		// Missing alpha reads as all ones
		set_formats(FMT_R8, FMT_A8);
		pending_pixels.push_back(32'h0000_0012);
		pending_pixels.push_back(32'hFFFF_FF00);
		drain_pipe();

		// Narrowing from 565 into 4444
		set_formats(FMT_BGR565, FMT_ARGB4444);
		pending_pixels.push_back(32'h0000_FFFF);
		pending_pixels.push_back(32'hFFFF_0000);
		pending_pixels.push_back(32'h0000_F81F);
		drain_pipe();

		// Unused format codes on either side give zero, then ARGB4444 into R8
		set_formats(FMT_UNUSED_LOW, FMT_RGBA8888);
		pending_pixels.push_back(32'hFFFF_FFFF);
		drain_pipe();
		set_formats(FMT_RGBA8888, FMT_UNUSED_TOP);
		pending_pixels.push_back(32'hFFFF_FFFF);
		drain_pipe();
		set_formats(FMT_ARGB4444, FMT_R8);
		pending_pixels.push_back(32'h0000_F00F);
		drain_pipe();

		// Random phases, the extreme settings first
		phase_no = 0;
		while (pixels_sent < RAND_ITEMS) begin
			idle_on = (phase_no % 5 == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
			case (phase_no)
				0:       random_phase(FMT_RGBA8888, FMT_RGBA8888, 60, 1'b1);
				1:       random_phase(FMT_ARGB4444, FMT_ARGB4444, 60, 1'b0);
				2:       random_phase(FMT_RGBA8888, FMT_ARGB4444, 60, 1'b0);
				3:       random_phase(FMT_ARGB4444, FMT_RGBA8888, 60, 1'b0);
				4:       random_phase(FMT_UNUSED_TOP, FMT_UNUSED_TOP, 20, 1'b0);
				default: random_phase(random_format(), random_format(),
					$urandom_range(10, 60), $urandom_range(0, 4) == 0);
			endcase
			phase_no++;
		end

		drain_pipe();
		if (expected_pixels.size() != 0) begin
			$display("%0t: %0d target pixels never arrived", $time, expected_pixels.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("packed_pixel_format_converter_unit test passed");
		else
			$display("packed_pixel_format_converter_unit test failed");
		$finish;
	end

endmodule

@@ packed_pixel_format_converter_unit.f @@
+incdir+hdl
hdl/ppfc_pkg.sv
hdl/ppfc_src_if.sv
hdl/ppfc_dst_if.sv
hdl/ppfc_convert.sv
hdl/packed_pixel_format_converter_unit.sv
test/tb_top.sv
